[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define LRSC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define LRSC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/lrsc_pkg.sv]
`timescale 1ns / 1ps

package lrsc_pkg;

	// Beat widths.
	localparam int IN_W  = 104;
	localparam int OUT_W = 32;
	localparam int CFG_W = 15;
	localparam int MUL_W = 17;

	// Q1.14 and Q1.16 units.
	localparam logic [14:0] ONE_Q14 = 15'd16384;
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// Target limits.
	localparam logic [14:0] BASE_MIN   = 15'd6554;
	localparam logic [14:0] BASE_MAX   = 15'd15565;
	localparam logic signed [16:0] TARGET_MIN = 17'sd5898;
	localparam logic signed [16:0] TARGET_MAX = 17'sd16056;

	// Arming thresholds.
	localparam logic [14:0] BRAKE_HOLD   = 15'd11468;
	localparam logic [14:0] CLUTCH_HOLD  = 15'd13107;
	localparam logic [14:0] THROTTLE_ARM = 15'd11796;
	localparam logic signed [15:0] SPEED_LIMIT = 16'sd512;
	localparam logic [3:0]  FIRST_GEAR   = 4'd1;

	// Frame time clamp and smoothing rates.
	localparam logic [15:0] DT_MIN = 16'd66;
	localparam logic [15:0] DT_MAX = 16'd3277;
	localparam logic [16:0] RATE_UP   = 17'd22;
	localparam logic [16:0] RATE_DOWN = 17'd9;

	// Excess / 0.12 is excess * 25 / 3; the request saturates from this excess on.
	localparam logic [14:0] EXCESS_SAT = 15'd1967;
	localparam logic [16:0] REQ_SCALE  = 17'd25;
	// ceil(2^17 / 3): x * RECIP_3 >> 17 equals x / 3 for every 16-bit x.
	localparam logic [16:0] RECIP_3    = 17'd43691;

	// Reset values of the registers.
	localparam logic [14:0] BASE_RESET = 15'd11469;
	localparam logic [14:0] AGGR_RESET = 15'd16384;

	typedef enum logic [1:0] {
		CFG_ENABLE = 2'd0,
		CFG_BASE   = 2'd1,
		CFG_OFFSET = 2'd2,
		CFG_AGGR   = 2'd3
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TARGET,
		ST_REQ_MUL,
		ST_REQ_DIV,
		ST_REQ,
		ST_RATE,
		ST_DELTA,
		ST_UPDATE,
		ST_SCALE,
		ST_THROTTLE,
		ST_DONE
	} state_t;

endpackage

[design/launch_rev_soft_cut.sv]
`timescale 1ns / 1ps

// Launch control soft cut. Each input beat carries one frame of driver and engine
// readings; the block answers with exactly one output beat holding the throttle to
// apply, the armed and limiting flags and the smoothed cut level, which it keeps
// from frame to frame. A frame passes from the accepting edge to the output register
// through a ten-step sequencer that runs every product through one shared 17 x 17
// multiplier, one product per cycle; s_tready is high only while the sequencer is
// idle, so a new frame is taken only after the previous one has left the sequencer.
// The output register lets the next frame be taken while the previous result still
// waits on m_tready; a frame that finishes while the old result is still held waits
// in its last step. Configuration writes are always accepted (cfg_ready is tied
// high) and must be made between frames.
module launch_rev_soft_cut (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// gear_number[3:0], clutch_disengage[18:4], throttle_in[33:19],
	// brake_in[48:34], road_speed[64:49], engine_running[65],
	// automatic_box[66], engine_rpm[81:67], frame_time[97:82], zeros above
	input  logic [lrsc_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// throttle_out[14:0], is_armed[15], is_limiting[16], cut_level_out[31:17]
	output logic [lrsc_pkg::OUT_W-1:0]    m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [lrsc_pkg::CFG_W-1:0]    cfg_data
);
	import lrsc_pkg::*;

	state_t state_q, state_next;

	// Configuration registers.
	logic        enable_q;
	logic [14:0] base_q;
	logic signed [13:0] offset_q;
	logic [14:0] aggr_q;

	// The one piece of state carried across frames.
	logic [14:0] cut_q;

	// Frame fields captured at the accepting edge.
	logic [3:0]  gear_q;
	logic [14:0] clutch_q;
	logic [14:0] thr_q;
	logic [14:0] brake_q;
	logic signed [15:0] speed_q;
	logic        eng_on_q;
	logic        autobox_q;
	logic [14:0] rpm_q;
	logic [11:0] dt_q;

	// Working registers of the sequence.
	logic        armed_q;
	logic        limiting_q;
	logic [14:0] excess_q;
	logic        sat_q;
	logic        up_q;
	logic [14:0] diff_q;
	logic        zero_q;

	// Shared multiplier.
	logic [MUL_W-1:0]   mul_a, mul_b;
	logic [2*MUL_W-1:0] prod_q;

	// Output register.
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	logic in_fire, out_free;

	// Combinational helpers for the individual steps.
	logic [15:0]        dt_raw;
	logic [14:0]        base_c;
	logic signed [16:0] tgt_sum;
	logic [14:0]        target;
	logic               held, armed_c;
	logic [14:0]        req;
	logic [16:0]        rate;
	logic [14:0]        step;
	logic [14:0]        cut_scaled;
	logic [14:0]        thr_scaled;
	logic [14:0]        thr_res;

	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// Target RPM: clamp the base, add the signed offset, clamp again.
	always_comb begin
		if (base_q < BASE_MIN) begin
			base_c = BASE_MIN;
		end else if (base_q > BASE_MAX) begin
			base_c = BASE_MAX;
		end else begin
			base_c = base_q;
		end
		tgt_sum = $signed({2'b00, base_c}) + 17'(offset_q);
		if (tgt_sum < TARGET_MIN) begin
			target = 15'(TARGET_MIN);
		end else if (tgt_sum > TARGET_MAX) begin
			target = 15'(TARGET_MAX);
		end else begin
			target = tgt_sum[14:0];
		end
	end

	// The driveline is held by the brake on an automatic box, by the clutch otherwise.
	assign held    = autobox_q ? (brake_q > BRAKE_HOLD) : (clutch_q > CLUTCH_HOLD);
	assign armed_c = enable_q && eng_on_q && (gear_q == FIRST_GEAR) && held &&
		(thr_q > THROTTLE_ARM) && (speed_q > -SPEED_LIMIT) && (speed_q < SPEED_LIMIT);

	// Requested cut; the divide by three has just been done through the reciprocal.
	always_comb begin
		if (!limiting_q) begin
			req = '0;
		end else if (sat_q) begin
			req = ONE_Q14;
		end else begin
			req = prod_q[31:17];
		end
	end

	// Smoothing rate saturates at one in Q1.16.
	assign rate = (prod_q > 34'(ONE_Q16)) ? ONE_Q16 : prod_q[16:0];
	assign step = prod_q[30:16];

	// Cut scaled by the aggression, then the throttle scaled by what is left.
	assign cut_scaled = prod_q[28:14];
	assign thr_scaled = (prod_q[28:14] > ONE_Q14) ? ONE_Q14 : prod_q[28:14];

	always_comb begin
		if (!limiting_q) begin
			thr_res = thr_q;
		end else if (zero_q) begin
			thr_res = '0;
		end else begin
			thr_res = thr_scaled;
		end
	end

	assign dt_raw = s_tdata[97:82];

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_fire) state_next = ST_TARGET;
			ST_TARGET:   state_next = ST_REQ_MUL;
			ST_REQ_MUL:  state_next = ST_REQ_DIV;
			ST_REQ_DIV:  state_next = ST_REQ;
			ST_REQ:      state_next = ST_RATE;
			ST_RATE:     state_next = ST_DELTA;
			ST_DELTA:    state_next = ST_UPDATE;
			ST_UPDATE:   state_next = ST_SCALE;
			ST_SCALE:    state_next = ST_THROTTLE;
			ST_THROTTLE: state_next = ST_DONE;
			ST_DONE:     if (out_free) state_next = ST_IDLE;
			default:     state_next = ST_IDLE;
		endcase
	end

	// Sequencer outputs: input handshake and the multiplier operands of each step.
	always_comb begin
		s_tready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_REQ_MUL: begin
				mul_a = {2'b00, excess_q};
				mul_b = REQ_SCALE;
			end
			ST_REQ_DIV: begin
				mul_a = {1'b0, prod_q[15:0]};
				mul_b = RECIP_3;
			end
			ST_RATE: begin
				mul_a = {5'b0, dt_q};
				mul_b = up_q ? RATE_UP : RATE_DOWN;
			end
			ST_DELTA: begin
				mul_a = {2'b00, diff_q};
				mul_b = rate;
			end
			ST_SCALE: begin
				mul_a = {2'b00, aggr_q};
				mul_b = {2'b00, cut_q};
			end
			ST_THROTTLE: begin
				mul_a = {2'b00, thr_q};
				mul_b = {2'b00, ONE_Q14 - cut_scaled};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// The scaled throttle product is held while the finished frame waits for the
	// output register.
	always_ff @(posedge clk) begin
		if (state_q != ST_DONE) begin
			prod_q <= mul_a * mul_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			base_q   <= BASE_RESET;
			offset_q <= '0;
			aggr_q   <= AGGR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_ENABLE: enable_q <= cfg_data[0];
				CFG_BASE:   base_q   <= cfg_data;
				CFG_OFFSET: offset_q <= $signed(cfg_data[13:0]);
				CFG_AGGR:   aggr_q   <= cfg_data;
				default:    enable_q <= enable_q;
			endcase
		end
	end

	// Smoothed cut moves toward the request by a step no larger than the gap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_q <= '0;
		end else if (state_q == ST_UPDATE) begin
			cut_q <= up_q ? cut_q + step : cut_q - step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Payload and working registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			gear_q    <= s_tdata[3:0];
			clutch_q  <= s_tdata[18:4];
			thr_q     <= s_tdata[33:19];
			brake_q   <= s_tdata[48:34];
			speed_q   <= $signed(s_tdata[64:49]);
			eng_on_q  <= s_tdata[65];
			autobox_q <= s_tdata[66];
			rpm_q     <= s_tdata[81:67];
			if (dt_raw < DT_MIN) begin
				dt_q <= 12'(DT_MIN);
			end else if (dt_raw > DT_MAX) begin
				dt_q <= 12'(DT_MAX);
			end else begin
				dt_q <= dt_raw[11:0];
			end
		end
		unique case (state_q)
			ST_TARGET: begin
				armed_q    <= armed_c;
				limiting_q <= armed_c && (rpm_q > target);
				excess_q   <= rpm_q - target;
				sat_q      <= (rpm_q - target) >= EXCESS_SAT;
			end
			ST_REQ: begin
				up_q   <= req > cut_q;
				diff_q <= (req > cut_q) ? req - cut_q : cut_q - req;
			end
			ST_THROTTLE: begin
				zero_q <= cut_scaled >= ONE_Q14;
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= {cut_q, limiting_q, armed_q, thr_res};
				end
			end
			default: begin
				zero_q <= zero_q;
			end
		endcase
	end

endmodule

[design/lrsc_chk.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lrsc_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [lrsc_pkg::OUT_W-1:0] m_tdata
);
	import lrsc_pkg::*;

	// A stalled output beat keeps its valid and its data.
	`LRSC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")

	// Frames are worked one at a time: the block is busy right after taking one.
	`LRSC_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input accepted while a frame is in work")

	// Limiting is only possible while armed.
	`LRSC_ASSERT_IMP(a_limit_armed, m_tvalid && m_tdata[16], m_tdata[15], "limiting without being armed")

	// The smoothed cut never leaves the unit range.
	`LRSC_ASSERT_IMP(a_cut_range, m_tvalid, m_tdata[31:17] <= ONE_Q14, "cut level above one")

endmodule

bind launch_rev_soft_cut lrsc_chk u_lrsc_chk (.*);
